// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the ID/index map.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define AST_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define AST_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/iim_pkg.sv -----
// Shared types and codes for the ID/index map.
// No dependencies.
`default_nettype none
package iim_pkg;
  localparam int MAX_ITEMS_DEF = 1024;
  localparam int ID_BITS_DEF   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 10;
  localparam int IDF_W    = 32;
  localparam int CNT_W    = 11;

  localparam logic [FUNC_W-1:0] F_ADD_AUTO = 3'd0;
  localparam logic [FUNC_W-1:0] F_ADD_ID   = 3'd1;
  localparam logic [FUNC_W-1:0] F_ADD_RUN  = 3'd2;
  localparam logic [FUNC_W-1:0] F_FIND     = 3'd3;
  localparam logic [FUNC_W-1:0] F_GET      = 3'd4;
  localparam logic [FUNC_W-1:0] F_CLEAR    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IN_USE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

  // queued transaction from front to back
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDF_W-1:0]  item_id;
    logic [IDX_W-1:0]  item_index;
    logic [CNT_W-1:0]  run_count;
  } cmd_t;
endpackage
`default_nettype wire

// ----- hw/rtl/iim_front.sv -----
// Front end: accepts transactions and queues them for the back end.
// Depends on iim_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module iim_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire iim_pkg::cmd_t in_cmd,
  output logic      q_valid,
  input  wire logic q_ready,
  output iim_pkg::cmd_t q_cmd
);
  import iim_pkg::*;
  // two-entry queue
  cmd_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `AST_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `AST_NXT(a_full_push, cnt_r == 2'd2 && !pop, cnt_r == 2'd2)
endmodule
`default_nettype wire

// ----- hw/rtl/iim_back.sv -----
// Back end: executes map operations against the ID memory.
// Depends on iim_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module iim_back #(
  parameter int MAX_ITEMS = iim_pkg::MAX_ITEMS_DEF,
  parameter int ID_BITS   = iim_pkg::ID_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire iim_pkg::cmd_t q_cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [iim_pkg::STATUS_W-1:0] out_status,
  output logic [iim_pkg::IDX_W-1:0]    out_result_index,
  output logic [iim_pkg::IDF_W-1:0]    out_result_id,
  output logic [iim_pkg::CNT_W-1:0]    out_entry_count
);
  import iim_pkg::*;
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int TW = $clog2(MAX_ITEMS + 1);
  localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SCHK, S_RUN, S_GET, S_DONE} st_t;
  st_t st_r;

  logic [ID_BITS-1:0] mem [MAX_ITEMS];
  logic [ID_BITS-1:0] rd_r;
  logic               we;
  logic [AW-1:0]      wa;
  logic [ID_BITS-1:0] wd;

  cmd_t               c_r;
  logic [TW-1:0]      tot_r;
  logic [ID_BITS-1:0] nid_r;
  logic [TW-1:0]      ptr_r;   // scan / run position
  logic [TW-1:0]      left_r;  // remaining run entries
  logic [ID_BITS-1:0] cid;
  logic [ID_BITS:0]   room_id;
  logic [TW:0]        room_tb;

  // decode of the transaction taken in idle
  st_t                 idle_st;
  logic [STATUS_W-1:0] idle_status;
  logic [IDX_W-1:0]    idle_index;
  logic [IDF_W-1:0]    idle_id;
  logic [TW-1:0]       idle_ptr;

  assign cid     = ID_BITS'(c_r.item_id);
  assign room_id = {1'b0, ID_MAX} - {1'b0, nid_r};
  assign room_tb = (TW+1)'(MAX_ITEMS) - {1'b0, tot_r};
  assign q_ready = (st_r == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ptr_r[AW-1:0]];
  end

  always_comb begin
    we = 1'b0; wa = tot_r[AW-1:0]; wd = nid_r;
    if (st_r == S_RUN) begin
      we = (left_r != '0); wa = ptr_r[AW-1:0];
    end else if (st_r == S_SCAN && ptr_r >= tot_r && c_r.func == F_ADD_ID
                 && tot_r < TW'(MAX_ITEMS)) begin
      we = 1'b1; wd = cid;
    end else if (st_r == S_IDLE && q_valid && q_ready && q_cmd.func == F_ADD_AUTO
                 && nid_r != ID_MAX && tot_r < TW'(MAX_ITEMS)) begin
      we = 1'b1;
    end
  end

  always_comb begin
    idle_st = S_DONE; idle_status = ST_OK; idle_index = '0; idle_id = '0; idle_ptr = '0;
    unique case (q_cmd.func)
      F_ADD_AUTO: begin
        if (nid_r == ID_MAX) idle_status = ST_EXHAUSTED;
        else if (tot_r >= TW'(MAX_ITEMS)) idle_status = ST_FULL;
        else begin
          idle_index = IDX_W'(tot_r); idle_id = IDF_W'(nid_r);
        end
      end
      F_ADD_ID, F_FIND: idle_st = S_SCAN;
      F_ADD_RUN: begin
        if (64'(q_cmd.run_count) > 64'(room_id)) idle_status = ST_EXHAUSTED;
        else if (64'(q_cmd.run_count) > 64'(room_tb)) idle_status = ST_FULL;
        else begin
          idle_index = IDX_W'(tot_r); idle_ptr = tot_r; idle_st = S_RUN;
        end
      end
      F_GET: begin
        if (32'(q_cmd.item_index) >= 32'(tot_r)) idle_status = ST_RANGE;
        else begin
          idle_ptr = TW'(q_cmd.item_index); idle_st = S_GET;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; tot_r <= '0; nid_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          c_r <= q_cmd;
          ptr_r <= idle_ptr;
          left_r <= TW'(q_cmd.run_count);
          out_status <= idle_status; out_result_index <= idle_index;
          out_result_id <= idle_id;
          st_r <= idle_st;
          if (q_cmd.func == F_ADD_AUTO && idle_status == ST_OK) begin
            tot_r <= tot_r + 1'b1; nid_r <= nid_r + 1'b1;
          end else if (q_cmd.func == F_CLEAR) begin
            tot_r <= '0; nid_r <= '0;
          end
        end
        S_SCAN: begin
          // memory read issued for ptr_r; compare next cycle
          if (c_r.func == F_ADD_ID && {32'b0, c_r.item_id} >= 64'(ID_MAX)) begin
            out_status <= ST_EXHAUSTED; st_r <= S_DONE;
          end else if (ptr_r >= tot_r) begin
            if (c_r.func == F_FIND) out_status <= ST_NOT_FOUND;
            else if (tot_r >= TW'(MAX_ITEMS)) out_status <= ST_FULL;
            else begin
              out_result_index <= IDX_W'(tot_r);
              tot_r <= tot_r + 1'b1;
              if (cid >= nid_r) nid_r <= cid + 1'b1;
            end
            st_r <= S_DONE;
          end else st_r <= S_SCHK;
        end
        S_SCHK: begin
          if (64'(rd_r) == {32'b0, c_r.item_id}) begin
            if (c_r.func == F_FIND) out_result_index <= IDX_W'(ptr_r);
            else out_status <= ST_IN_USE;
            st_r <= S_DONE;
          end else begin
            ptr_r <= ptr_r + 1'b1; st_r <= S_SCAN;
          end
        end
        S_RUN: begin
          if (left_r == '0) st_r <= S_DONE;
          else begin
            ptr_r <= ptr_r + 1'b1; left_r <= left_r - 1'b1;
            tot_r <= tot_r + 1'b1; nid_r <= nid_r + 1'b1;
          end
        end
        // read data for the get index lands in rd_r during done
        S_GET: st_r <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1; out_entry_count <= CNT_W'(tot_r); st_r <= S_IDLE;
          if (c_r.func == F_GET && out_status == ST_OK) out_result_id <= IDF_W'(rd_r);
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `AST_IMP(a_tot_max, 1'b1, tot_r <= TW'(MAX_ITEMS))
  `AST_NXT(a_done_valid, st_r == S_DONE, out_valid)
  `AST_IMP(a_no_accept_busy, out_valid, !q_ready)
endmodule
`default_nettype wire

// ----- hw/rtl/item_id_index_map_unit.sv -----
// Add auto, clear, unused codes and rejected runs or gets go from idle straight to done;
// an accepted get passes through a read state first. Find and add-given-id scan the table
// through one read port, with a scan state and a check state for each entry compared. Add
// run writes its entries in the run state. One transaction in the back end at a time; the
// next enters the cycle after the result is accepted, and a 2-entry queue takes input meanwhile.
// Sync active-low reset empties the table, zeroes next free ID.
`default_nettype none
module item_id_index_map_unit #(
  parameter int MAX_ITEMS = iim_pkg::MAX_ITEMS_DEF,
  parameter int ID_BITS   = iim_pkg::ID_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [iim_pkg::FUNC_W-1:0] in_func,
  input  wire logic [iim_pkg::IDF_W-1:0]  in_item_id,
  input  wire logic [iim_pkg::IDX_W-1:0]  in_item_index,
  input  wire logic [iim_pkg::CNT_W-1:0]  in_run_count,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [iim_pkg::STATUS_W-1:0] out_status,
  output logic [iim_pkg::IDX_W-1:0]    out_result_index,
  output logic [iim_pkg::IDF_W-1:0]    out_result_id,
  output logic [iim_pkg::CNT_W-1:0]    out_entry_count
);
  import iim_pkg::*;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  assign in_cmd = '{func: in_func, item_id: in_item_id,
                    item_index: in_item_index, run_count: in_run_count};

  iim_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_cmd,
                     .q_valid, .q_ready, .q_cmd);
  iim_back #(.MAX_ITEMS(MAX_ITEMS), .ID_BITS(ID_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .out_status, .out_result_index, .out_result_id, .out_entry_count);
endmodule
`default_nettype wire
